// ===== rtl/core/gtro_pkg.sv =====
`timescale 1ns / 1ps

package gtro_pkg;

	// pipeline depth of the three-lane normaliser, input to registered unit vector
	localparam int NRM_LAT = 55;

	// wide signed vector into the normaliser, three 64-bit lanes
	typedef logic [2:0][63:0] wvec_t;

	// Q2.14 unit vector, three 16-bit signed lanes
	typedef logic [2:0][15:0] uvec_t;

endpackage

// ===== rtl/core/gradient_tangent_reject_orient_unit.sv =====
// Throughput: one point per cycle; the whole pipeline holds while a result
// beat is stalled, and input is stalled only then.
// Built on two 55-stage normalisers (31 root stages, 15 divide stages each).
// Reset clears the valid bits only; the datapath registers are not reset.
`timescale 1ns / 1ps

module gradient_tangent_reject_orient_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic signed [31:0] grad_z,
	input  logic signed [15:0] norm_x,
	input  logic signed [15:0] norm_y,
	input  logic signed [15:0] norm_z,
	input  logic signed [31:0] tan_x,
	input  logic signed [31:0] tan_y,
	input  logic signed [31:0] tan_z,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] unit_x,
	output logic signed [15:0] unit_y,
	output logic signed [15:0] unit_z,
	output logic        [31:0] grad_length,
	output logic               last_out
);
	import gtro_pkg::*;

	localparam int NA      = NRM_LAT;
	localparam int LEN_STG = 32;			// root bits of the length
	localparam int LEN_DLY = 2 * NA + 5 - (LEN_STG + 2);

	typedef struct packed {
		logic [2:0][31:0] grad;
		logic [2:0][15:0] norm;
		logic             last;
	} side_t;

	logic en;

	// pipeline moves unless the result beat is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: input register
	logic               v_s1;
	logic signed [31:0] g_s1 [3];
	logic signed [31:0] t_s1 [3];
	side_t              sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1[0] <= grad_x;
			g_s1[1] <= grad_y;
			g_s1[2] <= grad_z;
			t_s1[0] <= tan_x;
			t_s1[1] <= tan_y;
			t_s1[2] <= tan_z;
			sd_s1.grad <= {grad_z, grad_y, grad_x};
			sd_s1.norm <= {norm_z, norm_y, norm_x};
			sd_s1.last <= last_point;
		end
	end

	// unit tangent
	wvec_t tan_vec;
	uvec_t utan;

	always_comb begin
		for (int i = 0; i < 3; i++) tan_vec[i] = 64'(t_s1[i]);
	end

	gtro_norm3 u_tan_norm (
		.clk  (clk),
		.en   (en),
		.vec  (tan_vec),
		.unit (utan)
	);

	// side line alongside the tangent normaliser
	logic  va_q [1:NA];
	side_t sa_q [1:NA];

	for (genvar k = 1; k <= NA; k++) begin : g_side_a
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_q[k] <= 1'b0;
			end else if (en) begin
				va_q[k] <= (k == 1) ? v_s1 : va_q[k == 1 ? 1 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) sa_q[k] <= (k == 1) ? sd_s1 : sa_q[k == 1 ? 1 : k-1];
		end
	end

	// rejection: d = g.u, r = g * 2^28 - d * u
	logic               v_d1, v_d2, v_r1, v_r2;
	side_t              sd_d1, sd_d2, sd_r1, sd_r2;
	uvec_t              u_d1, u_d2;
	logic signed [47:0] gu_d1 [3];
	logic signed [47:0] dot_d2;
	logic signed [63:0] du_r1 [3];
	logic signed [63:0] g64_c [3];
	wvec_t              rej_r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
		end else if (en) begin
			v_d1 <= va_q[NA];
			v_d2 <= v_d1;
			v_r1 <= v_d2;
			v_r2 <= v_r1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) g64_c[i] = 64'($signed(sd_r1.grad[i])) <<< 28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				gu_d1[i]  <= $signed(sa_q[NA].grad[i]) * $signed(utan[i]);
				du_r1[i]  <= dot_d2 * $signed(u_d2[i]);
				rej_r2[i] <= g64_c[i] - du_r1[i];
			end
			dot_d2 <= gu_d1[0] + gu_d1[1] + gu_d1[2];
			u_d1   <= utan;
			u_d2   <= u_d1;
			sd_d1  <= sa_q[NA];
			sd_d2  <= sd_d1;
			sd_r1  <= sd_d2;
			sd_r2  <= sd_r1;
		end
	end

	// unit remainder
	uvec_t unrm;

	gtro_norm3 u_rej_norm (
		.clk  (clk),
		.en   (en),
		.vec  (rej_r2),
		.unit (unrm)
	);

	// side line alongside the remainder normaliser
	logic  vb_q [1:NA];
	side_t sb_q [1:NA];

	for (genvar k = 1; k <= NA; k++) begin : g_side_b
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vb_q[k] <= 1'b0;
			end else if (en) begin
				vb_q[k] <= (k == 1) ? v_r2 : vb_q[k == 1 ? 1 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) sb_q[k] <= (k == 1) ? sd_r2 : sb_q[k == 1 ? 1 : k-1];
		end
	end

	// gradient length: squares, sum, then one root bit a stage
	logic [63:0] lsq_l1 [3];
	logic [63:0] lsum_l2;
	logic [63:0] lrem_l3  [LEN_STG];
	logic [31:0] lroot_l3 [LEN_STG];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) lsq_l1[i] <= g_s1[i] * g_s1[i];
			lsum_l2 <= lsq_l1[0] + lsq_l1[1] + lsq_l1[2];
		end
	end

	for (genvar k = 0; k < LEN_STG; k++) begin : g_len
		localparam int B = LEN_STG - 1 - k;
		logic [63:0] rem_in;
		logic [31:0] root_in;
		logic [64:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = lsum_l2;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = lrem_l3[k-1];
			assign root_in = lroot_l3[k-1];
		end

		assign trial = (65'(root_in) << (B + 1)) + (65'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					lrem_l3[k]  <= 64'({1'b0, rem_in} - trial);
					lroot_l3[k] <= root_in | (32'd1 << B);
				end else begin
					lrem_l3[k]  <= rem_in;
					lroot_l3[k] <= root_in;
				end
			end
		end
	end

	// length delay up to the orientation stage
	logic [31:0] len_q [1:LEN_DLY];

	for (genvar k = 1; k <= LEN_DLY; k++) begin : g_len_dly
		always_ff @(posedge clk) begin
			if (en) len_q[k] <= (k == 1) ? lroot_l3[LEN_STG-1] : len_q[k == 1 ? 1 : k-1];
		end
	end

	// orientation: products with the normal
	logic               v_o1;
	logic signed [31:0] pr_o1 [3];
	uvec_t              un_o1;
	logic               last_o1;
	logic signed [33:0] orient_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o1 <= 1'b0;
		end else if (en) begin
			v_o1 <= vb_q[NA];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_o1[i] <= $signed(unrm[i]) * $signed(sb_q[NA].norm[i]);
			end
			un_o1   <= unrm;
			last_o1 <= sb_q[NA].last;
		end
	end

	assign orient_c = 34'(pr_o1[0]) + 34'(pr_o1[1]) + 34'(pr_o1[2]);

	// result register, flip when facing away from the normal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_o1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_x      <= orient_c[33] ? -un_o1[0] : un_o1[0];
			unit_y      <= orient_c[33] ? -un_o1[1] : un_o1[1];
			unit_z      <= orient_c[33] ? -un_o1[2] : un_o1[2];
			grad_length <= len_q[LEN_DLY];
			last_out    <= last_o1;
		end
	end

endmodule

// ===== rtl/core/gtro_norm3.sv =====
`timescale 1ns / 1ps

module gtro_norm3 (
	input  logic            clk,
	input  logic            en,
	input  gtro_pkg::wvec_t vec,
	output gtro_pkg::uvec_t unit
);
	import gtro_pkg::*;

	localparam int SQ_STG = 31;	// root bits, sum of squares is below 2^62
	localparam int DV_STG = 15;	// quotient bits, quotient is at most 2^14
	localparam logic [5:0] TOP_POS = 6'd29;

	typedef struct packed {
		logic [2:0][29:0] nm;
		logic             zero;
		logic [2:0]       neg;
	} nside_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} dside_t;

	// stage 1: sign and magnitude
	logic [2:0][62:0] mag_s1;
	logic [2:0]       neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][63];
				mag_s1[i] <= vec[i][63] ? 63'(-vec[i]) : vec[i][62:0];
			end
		end
	end

	// stage 2: largest magnitude
	logic [62:0]      max_c;
	logic [62:0]      max_s2;
	logic [2:0][62:0] mag_s2;
	logic [2:0]       neg_s2;

	always_comb begin
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) max_c = mag_s1[1];
		if (mag_s1[2] > max_c) max_c = mag_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			max_s2 <= max_c;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: leading one inside each byte
	logic [63:0]     max_w;
	logic [7:0]      grp_nz_c;
	logic [7:0][2:0] grp_pos_c;
	logic [7:0]      grp_nz_s3;
	logic [7:0][2:0] grp_pos_s3;
	logic [2:0][62:0] mag_s3;
	logic [2:0]       neg_s3;

	assign max_w = {1'b0, max_s2};

	always_comb begin
		for (int g = 0; g < 8; g++) begin
			grp_nz_c[g]  = |max_w[g*8 +: 8];
			grp_pos_c[g] = '0;
			for (int j = 0; j < 8; j++) begin
				if (max_w[g*8 + j]) grp_pos_c[g] = 3'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_nz_s3  <= grp_nz_c;
			grp_pos_s3 <= grp_pos_c;
			mag_s3     <= mag_s2;
			neg_s3     <= neg_s2;
		end
	end

	// stage 4: leading one of the whole word
	logic [5:0]       lead_c;
	logic [5:0]       lead_s4;
	logic             zero_s4;
	logic [2:0][62:0] mag_s4;
	logic [2:0]       neg_s4;

	always_comb begin
		lead_c = '0;
		for (int g = 0; g < 8; g++) begin
			if (grp_nz_s3[g]) lead_c = {3'(g), grp_pos_s3[g]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lead_s4 <= lead_c;
			zero_s4 <= ~|grp_nz_s3;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// stage 5: common shift, largest lands in [2^29, 2^30)
	nside_t side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (lead_s4 >= TOP_POS)
					side_s5.nm[i] <= 30'(mag_s4[i] >> (lead_s4 - TOP_POS));
				else
					side_s5.nm[i] <= 30'(mag_s4[i] << (TOP_POS - lead_s4));
			end
			side_s5.zero <= zero_s4;
			side_s5.neg  <= neg_s4;
		end
	end

	// stage 6: squares
	logic [2:0][59:0] sq_s6;
	nside_t           side_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s6[i] <= side_s5.nm[i] * side_s5.nm[i];
			side_s6 <= side_s5;
		end
	end

	// stage 7: sum of squares
	logic [61:0] sum_s7;
	nside_t      side_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= 62'(sq_s6[0]) + 62'(sq_s6[1]) + 62'(sq_s6[2]);
			side_s7 <= side_s6;
		end
	end

	// stages 8..38: square root, one result bit a stage
	logic [63:0] sq_rem_s8  [SQ_STG];
	logic [30:0] sq_root_s8 [SQ_STG];
	nside_t      sq_side_s8 [SQ_STG];

	for (genvar k = 0; k < SQ_STG; k++) begin : g_sqrt
		localparam int B = SQ_STG - 1 - k;
		logic [63:0] rem_in;
		logic [63:0] trial;
		logic [30:0] root_in;
		nside_t      side_in;

		if (k == 0) begin : g_first
			assign rem_in  = 64'(sum_s7);
			assign root_in = '0;
			assign side_in = side_s7;
		end else begin : g_next
			assign rem_in  = sq_rem_s8[k-1];
			assign root_in = sq_root_s8[k-1];
			assign side_in = sq_side_s8[k-1];
		end

		assign trial = (64'(root_in) << (B + 1)) + (64'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					sq_rem_s8[k]  <= rem_in - trial;
					sq_root_s8[k] <= root_in | (31'd1 << B);
				end else begin
					sq_rem_s8[k]  <= rem_in;
					sq_root_s8[k] <= root_in;
				end
				sq_side_s8[k] <= side_in;
			end
		end
	end

	// stage 39: rounded numerators
	logic [2:0][44:0] num_s39;
	logic [30:0]      len_s39;
	dside_t           side_s39;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s39[i] <= {1'b0, sq_side_s8[SQ_STG-1].nm[i], 14'd0}
					+ 45'(sq_root_s8[SQ_STG-1] >> 1);
			end
			len_s39       <= sq_root_s8[SQ_STG-1];
			side_s39.zero <= sq_side_s8[SQ_STG-1].zero;
			side_s39.neg  <= sq_side_s8[SQ_STG-1].neg;
		end
	end

	// stages 40..54: restoring division, one quotient bit a stage
	logic [2:0][44:0] dv_rem_s40  [DV_STG];
	logic [2:0][14:0] dv_q_s40    [DV_STG];
	logic [30:0]      dv_len_s40  [DV_STG];
	dside_t           dv_side_s40 [DV_STG];

	for (genvar k = 0; k < DV_STG; k++) begin : g_div
		localparam int B = DV_STG - 1 - k;
		logic [2:0][44:0] rem_in;
		logic [2:0][14:0] q_in;
		logic [30:0]      len_in;
		dside_t           side_in;
		logic [44:0]      den;

		if (k == 0) begin : g_first
			assign rem_in  = num_s39;
			assign q_in    = '0;
			assign len_in  = len_s39;
			assign side_in = side_s39;
		end else begin : g_next
			assign rem_in  = dv_rem_s40[k-1];
			assign q_in    = dv_q_s40[k-1];
			assign len_in  = dv_len_s40[k-1];
			assign side_in = dv_side_s40[k-1];
		end

		assign den = 45'(len_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_in[i] >= den) begin
						dv_rem_s40[k][i] <= rem_in[i] - den;
						dv_q_s40[k][i]   <= q_in[i] | (15'd1 << B);
					end else begin
						dv_rem_s40[k][i] <= rem_in[i];
						dv_q_s40[k][i]   <= q_in[i];
					end
				end
				dv_len_s40[k]  <= len_in;
				dv_side_s40[k] <= side_in;
			end
		end
	end

	// stage 55: restore signs, zero vector gives zero
	uvec_t unit_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_side_s40[DV_STG-1].zero)
					unit_s55[i] <= '0;
				else if (dv_side_s40[DV_STG-1].neg[i])
					unit_s55[i] <= -{1'b0, dv_q_s40[DV_STG-1][i]};
				else
					unit_s55[i] <= {1'b0, dv_q_s40[DV_STG-1][i]};
			end
		end
	end

	assign unit = unit_s55;

endmodule

// ===== verif/gradient_tangent_reject_orient_unit_tb.sv =====
`timescale 1ns / 1ps

module gradient_tangent_reject_orient_unit_tb;

	import gtro_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 140;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_POINTS  = 500;
	localparam int UNIT_ONE       = 16384;

	typedef longint signed trip_t [3];

	typedef struct {
		logic signed [31:0] gx, gy, gz;
		logic signed [15:0] nx, ny, nz;
		logic signed [31:0] tx, ty, tz;
		logic               lst;
	} point_t;

	typedef struct {
		logic signed [15:0] ux, uy, uz;
		logic        [31:0] len;
		logic               lst;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] grad_x, grad_y, grad_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic signed [31:0] tan_x, tan_y, tan_z;
	logic               last_point;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] unit_x, unit_y, unit_z;
	logic        [31:0] grad_length;
	logic               last_out;

	result_t pending_units[$];
	point_t  dir_pts[$];
	result_t dir_res[$];
	bit      dir_known[$];
	int      mismatches;
	int      send_idle_pct;
	int      recv_stall_pct;
	bit      hold_req;

	gradient_tangent_reject_orient_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.grad_x      (grad_x),
		.grad_y      (grad_y),
		.grad_z      (grad_z),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.tan_x       (tan_x),
		.tan_y       (tan_y),
		.tan_z       (tan_z),
		.last_point  (last_point),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.unit_x      (unit_x),
		.unit_y      (unit_y),
		.unit_z      (unit_z),
		.grad_length (grad_length),
		.last_out    (last_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b   = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s   -= res + b;
				res  = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// scale to [2^29, 2^30), divide by the floor length with rounding -> Q2.14
	function automatic void unitise(input trip_t v, output trip_t u);
		longint unsigned mag[3];
		bit              neg[3];
		longint unsigned top, len, total, q;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > top)
				top = mag[i];
		end
		if (top == 0) begin
			for (int i = 0; i < 3; i++)
				u[i] = 0;
			return;
		end
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		total = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		len   = int_sqrt(total);
		for (int i = 0; i < 3; i++) begin
			q    = (mag[i] * 16384 + len / 2) / len;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end
	endfunction

	// tangent rejection, normalise, orient against the normal
	function automatic result_t orient_gradient(input point_t p);
		result_t         r;
		trip_t           g, n, t, ut, rem, un;
		longint signed   d, s;
		longint unsigned lsum, a;
		g = '{longint'(p.gx), longint'(p.gy), longint'(p.gz)};
		n = '{longint'(p.nx), longint'(p.ny), longint'(p.nz)};
		t = '{longint'(p.tx), longint'(p.ty), longint'(p.tz)};
		lsum = 0;
		for (int i = 0; i < 3; i++) begin
			a     = (g[i] < 0) ? longint'(-g[i]) : longint'(g[i]);
			lsum += a * a;
		end
		unitise(t, ut);
		d = 0;
		for (int i = 0; i < 3; i++)
			d += g[i] * ut[i];
		for (int i = 0; i < 3; i++)
			rem[i] = g[i] * (64'sd1 <<< 28) - d * ut[i];
		unitise(rem, un);
		s = 0;
		for (int i = 0; i < 3; i++)
			s += un[i] * n[i];
		if (s < 0)
			for (int i = 0; i < 3; i++)
				un[i] = -un[i];
		r.ux  = un[0][15:0];
		r.uy  = un[1][15:0];
		r.uz  = un[2][15:0];
		r.len = int_sqrt(lsum);
		r.lst = p.lst;
		return r;
	endfunction

	function automatic point_t mk_point(input longint gx, gy, gz, nx, ny, nz,
			tx, ty, tz, input bit lst);
		point_t p;
		p.gx = gx; p.gy = gy; p.gz = gz;
		p.nx = nx; p.ny = ny; p.nz = nz;
		p.tx = tx; p.ty = ty; p.tz = tz;
		p.lst = lst;
		return p;
	endfunction

	// known: expectation typed in here, otherwise taken from the predictor
	task automatic add_row(input point_t p, input bit known,
			input longint ux = 0, uy = 0, uz = 0, len = 0);
		result_t r;
		r.ux = ux; r.uy = uy; r.uz = uz; r.len = len; r.lst = p.lst;
		dir_pts.insert(dir_pts.size(), p);
		dir_res.insert(dir_res.size(), r);
		dir_known.insert(dir_known.size(), known);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 255) - 128;
			1: return $urandom_range(0, 32'h1ffff) - 32'h10000;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		int     k;
		p.gx = rand_word(); p.gy = rand_word(); p.gz = rand_word();
		p.tx = rand_word(); p.ty = rand_word(); p.tz = rand_word();
		p.nx = $urandom; p.ny = $urandom; p.nz = $urandom;
		p.lst = $urandom_range(0, 1);
		case ($urandom_range(0, 9))
			0: begin
				p.tx = 0; p.ty = 0; p.tz = 0;
			end
			1: begin
				// gradient along the tangent
				k    = $urandom_range(1, 64) - 32;
				p.tx = $signed($urandom_range(0, 65535)) - 32768;
				p.ty = $signed($urandom_range(0, 65535)) - 32768;
				p.tz = $signed($urandom_range(0, 65535)) - 32768;
				p.gx = p.tx * k; p.gy = p.ty * k; p.gz = p.tz * k;
			end
			2: begin
				p.gx = 0; p.gy = 0; p.gz = 0;
			end
			3: begin
				p.nx = 0; p.ny = 0; p.nz = 0;
			end
			default: ;
		endcase
		return p;
	endfunction

	// offer one point; returns after it is accepted
	task automatic send_point(input point_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		grad_x = p.gx; grad_y = p.gy; grad_z = p.gz;
		norm_x = p.nx; norm_y = p.ny; norm_z = p.nz;
		tan_x  = p.tx; tan_y  = p.ty; tan_z  = p.tz;
		last_point = p.lst;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		@(negedge clk);
	endtask

	// result side stalls
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				out_stall = 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end
			out_stall = ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// expectations recorded on the accepted input beat
	always @(posedge clk) begin
		result_t r;
		if (arst_n && in_valid && !in_stall) begin
			r = orient_gradient('{grad_x, grad_y, grad_z, norm_x, norm_y, norm_z,
				tan_x, tan_y, tan_z, last_point});
			pending_units.insert(pending_units.size(), r);
		end
	end

	// result beat check
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_units.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat unit=%0d,%0d,%0d len=%0d",
					$time, unit_x, unit_y, unit_z, grad_length);
			end else begin
				e = pending_units.pop_front();
				if (unit_x !== e.ux || unit_y !== e.uy || unit_z !== e.uz ||
						grad_length !== e.len || last_out !== e.lst) begin
					mismatches++;
					$display("%0t: expected unit=%0d,%0d,%0d len=%0d last=%0b",
						$time, e.ux, e.uy, e.uz, e.len, e.lst);
					$display("%0t:   actual unit=%0d,%0d,%0d len=%0d last=%0b",
						$time, unit_x, unit_y, unit_z, grad_length, last_out);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		result_t fixed_res;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		grad_x = 0; grad_y = 0; grad_z = 0;
		norm_x = 0; norm_y = 0; norm_z = 0;
		tan_x  = 0; tan_y  = 0; tan_z  = 0;
		last_point = 1'b0;

		// directed table
		add_row(mk_point(0, 0, 0, UNIT_ONE, 0, 0, 65536, 0, 0, 0), 1, 0, 0, 0, 0);
		add_row(mk_point(65536, 0, 0, UNIT_ONE, 0, 0, 0, 0, 0, 1), 1,
			UNIT_ONE, 0, 0, 65536);
		add_row(mk_point(65536, 0, 0, -UNIT_ONE, 0, 0, 0, 0, 0, 0), 1,
			-UNIT_ONE, 0, 0, 65536);
		add_row(mk_point(0, 65536, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, UNIT_ONE, 0, 65536);
		add_row(mk_point(0, 0, 65536, UNIT_ONE, 0, 0, 0, 0, 0, 0), 1,
			0, 0, UNIT_ONE, 65536);
		add_row(mk_point(65536, 0, 0, UNIT_ONE, 0, 0, 3, 0, 0, 1), 1, 0, 0, 0, 65536);
		add_row(mk_point(0, -65536, 0, UNIT_ONE, UNIT_ONE, 0, 1, 0, 0, 0), 1,
			0, UNIT_ONE, 0, 65536);
		add_row(mk_point(131072, 65536, 0, 0, 0, UNIT_ONE, 0, 0, 65536, 0), 0);
		add_row(mk_point(-2147483648, -2147483648, -2147483648, -32768, -32768,
			-32768, 0, 0, 0, 1), 0);
		add_row(mk_point(2147483647, 2147483647, 2147483647, 32767, 32767, 32767,
			-2147483648, 2147483647, 0, 0), 0);
		add_row(mk_point(2147483647, -2147483648, 1, 32767, -32768, 0,
			2147483647, 2147483647, 2147483647, 1), 0);
		add_row(mk_point(1, 0, 0, 0, 0, 0, 0, 1, 0, 0), 0);
		add_row(mk_point(1, 1, 1, -1, 0, 0, -1, -1, -1, 1), 0);
		add_row(mk_point(-1, 2, -3, 100, -200, 300, 2147483647, 1, -1, 0), 0);
		add_row(mk_point(123456789, -987654, 55555, -5000, 3000, 12000,
			-65536, 131072, 7, 1), 0);
		add_row(mk_point(-2147483648, 0, 0, UNIT_ONE, 0, 0, -2147483648, 0, 0, 0), 0);
		add_row(mk_point(65536, 65536, 0, 0, 0, -32768, 65536, -65536, 0, 1), 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < dir_pts.size(); i++) begin
			if (dir_known[i]) begin
				fixed_res = orient_gradient(dir_pts[i]);
				if (fixed_res.ux !== dir_res[i].ux || fixed_res.uy !== dir_res[i].uy ||
						fixed_res.uz !== dir_res[i].uz ||
						fixed_res.len !== dir_res[i].len) begin
					mismatches++;
					$display("%0t: row %0d expected unit=%0d,%0d,%0d len=%0d", $time, i,
						dir_res[i].ux, dir_res[i].uy, dir_res[i].uz, dir_res[i].len);
					$display("%0t: row %0d   actual unit=%0d,%0d,%0d len=%0d", $time, i,
						fixed_res.ux, fixed_res.uy, fixed_res.uz, fixed_res.len);
				end
			end
			send_point(dir_pts[i]);
		end

		// random phases: one long result hold, sender idle, result stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			for (int i = 0; i < RANDOM_POINTS / 4; i++)
				send_point(rand_point());
		end
		in_valid      = 1'b0;
		send_idle_pct = 0;

		while (pending_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_units.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
